FILE: src/crbb_pkg.sv
`timescale 1ns / 1ps

package crbb_pkg;

  localparam int COLOR_W         = 24;
  localparam int BOX_W           = 12;
  localparam int SLOT_W          = 8;
  localparam int COUNT_W         = 9;

  localparam int MAX_REGIONS_DEF = 256;
  localparam int COORD_WIDTH_DEF = 12;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_READ   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_READ,
    S_DONE
  } state_e;

  typedef struct packed {
    op_e                operation;
    logic [COLOR_W-1:0] color;
    logic [BOX_W-1:0]   row;
    logic [BOX_W-1:0]   column;
    logic [SLOT_W-1:0]  slot;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  entry_slot;
    logic               is_new;
    logic               table_full;
    logic               entry_valid;
    logic [COLOR_W-1:0] entry_color;
    logic [BOX_W-1:0]   box_top;
    logic [BOX_W-1:0]   box_bottom;
    logic [BOX_W-1:0]   box_left;
    logic [BOX_W-1:0]   box_right;
    logic [COUNT_W-1:0] entry_count;
  } rsp_t;

endpackage

FILE: src/crbb_if.sv
`timescale 1ns / 1ps

interface crbb_req_if import crbb_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface crbb_rsp_if import crbb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: src/color_region_bounding_box_table.sv
// Read request: the entry memory is read and the result passes through S_READ and
// S_DONE to the output register; when the slot holds no entry, S_READ is skipped.
// Record request: the stored entries are searched in insertion order, one entry memory
// read each, until a colour hit or the last entry; an empty table is not read.
// Next request is taken the cycle after the result is handed over.
// Reset clears the entry count and all handshake state; entry memory is not cleared.
`timescale 1ns / 1ps

module color_region_bounding_box_table import crbb_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crbb_req_if.sink   req_i,
  crbb_rsp_if.source rsp_o
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = (COORD_WIDTH < BOX_W) ? COORD_WIDTH : BOX_W;
  localparam int EW = COLOR_W + 4 * CW;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic          seq_done, seq_take;
  rsp_t          seq_result;

  logic          out_valid_q, out_valid_d;
  rsp_t          out_data_q, out_data_d;

  crbb_mem #(
    .DEPTH (MAX_REGIONS),
    .WIDTH (EW),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  crbb_seq #(
    .MAX_REGIONS (MAX_REGIONS),
    .COORD_WIDTH (COORD_WIDTH),
    .AW          (AW),
    .EW          (EW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .in_req_i    (req_i.payload),
    .done_o      (seq_done),
    .result_o    (seq_result),
    .take_i      (seq_take),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register frees the sequencer while a result waits downstream
  assign seq_take = seq_done && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (seq_take) begin
      out_valid_d = 1'b1;
      out_data_d  = seq_result;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_data_q;

endmodule

FILE: src/crbb_mem.sv
`timescale 1ns / 1ps

module crbb_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 72,
  parameter int AW    = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/crbb_seq.sv
`timescale 1ns / 1ps

module crbb_seq import crbb_pkg::*; #(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int AW          = 8,
  parameter int EW          = 72
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  req_t          in_req_i,
  output logic          done_o,
  output rsp_t          result_o,
  input  logic          take_i,
  output logic          mem_we_o,
  output logic [AW-1:0] mem_waddr_o,
  output logic [EW-1:0] mem_wdata_o,
  output logic          mem_re_o,
  output logic [AW-1:0] mem_raddr_o,
  input  logic [EW-1:0] mem_rdata_i
);

  localparam int TW   = $clog2(MAX_REGIONS + 1);
  localparam int CW   = (COORD_WIDTH < BOX_W) ? COORD_WIDTH : BOX_W;
  // entry layout, low to high: right, left, bottom, top, colour
  localparam int L_LO = CW;
  localparam int B_LO = 2 * CW;
  localparam int T_LO = 3 * CW;
  localparam int C_LO = 4 * CW;

  state_e             state_q, state_d;
  logic [COLOR_W-1:0] color_q, color_d;
  logic [CW-1:0]      row_q, row_d;
  logic [CW-1:0]      col_q, col_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [TW-1:0]      k_q, k_d;
  logic [AW-1:0]      kr_q, kr_d;
  logic               rvalid_q, rvalid_d;
  logic [TW-1:0]      total_q, total_d;
  rsp_t               result_q, result_d;

  logic [COLOR_W-1:0] rd_color;
  logic [CW-1:0]      rd_top, rd_bottom, rd_left, rd_right;
  logic [CW-1:0]      up_top, up_bottom, up_left, up_right;
  logic               hit;
  logic [EW-1:0]      upd_entry, new_entry;

  assign rd_color  = mem_rdata_i[C_LO +: COLOR_W];
  assign rd_top    = mem_rdata_i[T_LO +: CW];
  assign rd_bottom = mem_rdata_i[B_LO +: CW];
  assign rd_left   = mem_rdata_i[L_LO +: CW];
  assign rd_right  = mem_rdata_i[0 +: CW];

  assign hit       = rvalid_q && (rd_color == color_q);

  assign up_top    = (row_q < rd_top)    ? row_q : rd_top;
  assign up_bottom = (row_q > rd_bottom) ? row_q : rd_bottom;
  assign up_left   = (col_q < rd_left)   ? col_q : rd_left;
  assign up_right  = (col_q > rd_right)  ? col_q : rd_right;

  assign upd_entry = {color_q, up_top, up_bottom, up_left, up_right};
  assign new_entry = {color_q, row_q, row_q, col_q, col_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      k_q      <= '0;
      rvalid_q <= 1'b0;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      k_q      <= k_d;
      rvalid_q <= rvalid_d;
      total_q  <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q  <= color_d;
    row_q    <= row_d;
    col_q    <= col_d;
    slot_q   <= slot_d;
    kr_q     <= kr_d;
    result_q <= result_d;
  end

  always_comb begin
    state_d     = state_q;
    color_d     = color_q;
    row_d       = row_q;
    col_d       = col_q;
    slot_d      = slot_q;
    k_d         = k_q;
    kr_d        = kr_q;
    rvalid_d    = rvalid_q;
    total_d     = total_q;
    result_d    = result_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = kr_q;
    mem_wdata_o = upd_entry;
    mem_re_o    = 1'b0;
    mem_raddr_o = k_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          color_d = in_req_i.color;
          row_d   = in_req_i.row[CW-1:0];
          col_d   = in_req_i.column[CW-1:0];
          slot_d  = in_req_i.slot;
          if (in_req_i.operation == OP_READ) begin
            if (32'(in_req_i.slot) < 32'(total_q)) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(in_req_i.slot);
              state_d     = S_READ;
            end else begin
              result_d             = '0;
              result_d.entry_slot  = in_req_i.slot;
              result_d.entry_count = COUNT_W'(total_q);
              state_d              = S_DONE;
            end
          end else begin
            // empty table: go straight to the append decision
            mem_re_o    = (total_q != '0);
            mem_raddr_o = '0;
            rvalid_d    = (total_q != '0);
            k_d         = (total_q != '0) ? TW'(1) : '0;
            kr_d        = '0;
            state_d     = S_SEARCH;
          end
        end
      end

      S_SEARCH: begin
        if (hit) begin
          mem_we_o             = 1'b1;
          mem_waddr_o          = kr_q;
          mem_wdata_o          = upd_entry;
          result_d             = '0;
          result_d.entry_slot  = SLOT_W'(kr_q);
          result_d.entry_valid = 1'b1;
          result_d.entry_color = color_q;
          result_d.box_top     = BOX_W'(up_top);
          result_d.box_bottom  = BOX_W'(up_bottom);
          result_d.box_left    = BOX_W'(up_left);
          result_d.box_right   = BOX_W'(up_right);
          result_d.entry_count = COUNT_W'(total_q);
          rvalid_d             = 1'b0;
          state_d              = S_DONE;
        end else if (k_q == total_q) begin
          result_d = '0;
          rvalid_d = 1'b0;
          state_d  = S_DONE;
          if (total_q == TW'(MAX_REGIONS)) begin
            result_d.table_full  = 1'b1;
            result_d.entry_count = COUNT_W'(total_q);
          end else begin
            mem_we_o             = 1'b1;
            mem_waddr_o          = total_q[AW-1:0];
            mem_wdata_o          = new_entry;
            total_d              = total_q + TW'(1);
            result_d.entry_slot  = SLOT_W'(total_q);
            result_d.is_new      = 1'b1;
            result_d.entry_valid = 1'b1;
            result_d.entry_color = color_q;
            result_d.box_top     = BOX_W'(row_q);
            result_d.box_bottom  = BOX_W'(row_q);
            result_d.box_left    = BOX_W'(col_q);
            result_d.box_right   = BOX_W'(col_q);
            result_d.entry_count = COUNT_W'(total_q + TW'(1));
          end
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = k_q[AW-1:0];
          kr_d        = k_q[AW-1:0];
          k_d         = k_q + TW'(1);
          rvalid_d    = 1'b1;
        end
      end

      S_READ: begin
        result_d             = '0;
        result_d.entry_slot  = slot_q;
        result_d.entry_valid = 1'b1;
        result_d.entry_color = rd_color;
        result_d.box_top     = BOX_W'(rd_top);
        result_d.box_bottom  = BOX_W'(rd_bottom);
        result_d.box_left    = BOX_W'(rd_left);
        result_d.box_right   = BOX_W'(rd_right);
        result_d.entry_count = COUNT_W'(total_q);
        state_d              = S_DONE;
      end

      S_DONE: begin
        if (take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign done_o     = (state_q == S_DONE);
  assign result_o   = result_q;

endmodule

FILE: src/crbb_checker.sv
`timescale 1ns / 1ps

module crbb_checker import crbb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic rsp_valid_i,
  input logic rsp_ready_i,
  input rsp_t rsp_data_i
);

  logic [1:0]         pending_q;
  logic [COUNT_W-1:0] last_count_q;
  logic               req_fire, rsp_fire;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      last_count_q <= '0;
    end else begin
      pending_q <= pending_q + {1'b0, req_fire} - {1'b0, rsp_fire};
      if (rsp_fire) begin
        last_count_q <= rsp_data_i.entry_count;
      end
    end
  end

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_data_i))
    else $error("response payload changed while stalled");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 2'd0)
    else $error("response without an outstanding request");

  a_pending_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 2'd2)
    else $error("more requests in flight than the block can hold");

  // the table only ever grows by one entry per request
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_fire |-> (rsp_data_i.entry_count == last_count_q) ||
                 (rsp_data_i.entry_count == last_count_q + COUNT_W'(1)))
    else $error("entry count stepped by more than one");

endmodule

bind color_region_bounding_box_table crbb_checker u_crbb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_data_i  (rsp_o.payload)
);

FILE: tb/sv/color_region_bounding_box_table_test.sv
`timescale 1ns / 1ps

module color_region_bounding_box_table_test;
  import crbb_pkg::*;

  localparam int TABLE_DEPTH = MAX_REGIONS_DEF;
  localparam logic [BOX_W-1:0] COORD_MASK = BOX_W'((1 << COORD_WIDTH_DEF) - 1);
  localparam logic [COLOR_W-1:0] COLOR_MAX = {COLOR_W{1'b1}};
  localparam logic [BOX_W-1:0] COORD_MAX = {BOX_W{1'b1}};

  logic clk;
  logic rst_n;

  crbb_req_if req_if ();
  crbb_rsp_if rsp_if ();

  color_region_bounding_box_table dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow of the region table
  logic [COLOR_W-1:0] shadow_color  [TABLE_DEPTH];
  logic [BOX_W-1:0]   shadow_top    [TABLE_DEPTH];
  logic [BOX_W-1:0]   shadow_bottom [TABLE_DEPTH];
  logic [BOX_W-1:0]   shadow_left   [TABLE_DEPTH];
  logic [BOX_W-1:0]   shadow_right  [TABLE_DEPTH];
  int unsigned        shadow_total;

  req_t               pixel_requests [$];
  rsp_t               expected_lookups [$];
  logic [COLOR_W-1:0] issued_colors [$];

  int unsigned queued_total;
  int unsigned accepted_total;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned stall_left;
  int unsigned send_calm;
  int unsigned stall_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Short gaps mostly, a few long ones, and now and then a run with none at all
  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (p < 3) calm = $urandom_range(20, 60);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic rsp_t region_view(int unsigned idx);
    rsp_t res;
    res             = '0;
    res.entry_slot  = SLOT_W'(idx);
    res.entry_valid = 1'b1;
    res.entry_color = shadow_color[idx];
    res.box_top     = shadow_top[idx];
    res.box_bottom  = shadow_bottom[idx];
    res.box_left    = shadow_left[idx];
    res.box_right   = shadow_right[idx];
    res.entry_count = COUNT_W'(shadow_total);
    return res;
  endfunction

  function automatic rsp_t lookup_region(req_t r);
    rsp_t             res;
    logic [BOX_W-1:0] y;
    logic [BOX_W-1:0] x;
    int               hit;
    res = '0;
    y   = r.row & COORD_MASK;
    x   = r.column & COORD_MASK;
    hit = -1;
    if (r.operation == OP_READ) begin
      if (r.slot < shadow_total) return region_view(r.slot);
      res.entry_slot  = r.slot;
      res.entry_count = COUNT_W'(shadow_total);
      return res;
    end
    for (int k = 0; k < shadow_total; k++) begin
      if (hit < 0 && shadow_color[k] == r.color) hit = k;
    end
    if (hit >= 0) begin
      if (y < shadow_top[hit]) shadow_top[hit] = y;
      if (y > shadow_bottom[hit]) shadow_bottom[hit] = y;
      if (x < shadow_left[hit]) shadow_left[hit] = x;
      if (x > shadow_right[hit]) shadow_right[hit] = x;
      return region_view(hit);
    end
    if (shadow_total >= TABLE_DEPTH) begin
      res.table_full  = 1'b1;
      res.entry_count = COUNT_W'(shadow_total);
      return res;
    end
    shadow_color[shadow_total]  = r.color;
    shadow_top[shadow_total]    = y;
    shadow_bottom[shadow_total] = y;
    shadow_left[shadow_total]   = x;
    shadow_right[shadow_total]  = x;
    shadow_total++;
    res        = region_view(shadow_total - 1);
    res.is_new = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t ns: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic check_result(rsp_t got, rsp_t want);
    if (got.entry_slot !== want.entry_slot)
      report_mismatch("entry_slot", got.entry_slot, want.entry_slot);
    if (got.is_new !== want.is_new)
      report_mismatch("is_new", got.is_new, want.is_new);
    if (got.table_full !== want.table_full)
      report_mismatch("table_full", got.table_full, want.table_full);
    if (got.entry_valid !== want.entry_valid)
      report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
    if (got.entry_color !== want.entry_color)
      report_mismatch("entry_color", got.entry_color, want.entry_color);
    if (got.box_top !== want.box_top)
      report_mismatch("box_top", got.box_top, want.box_top);
    if (got.box_bottom !== want.box_bottom)
      report_mismatch("box_bottom", got.box_bottom, want.box_bottom);
    if (got.box_left !== want.box_left)
      report_mismatch("box_left", got.box_left, want.box_left);
    if (got.box_right !== want.box_right)
      report_mismatch("box_right", got.box_right, want.box_right);
    if (got.entry_count !== want.entry_count)
      report_mismatch("entry_count", got.entry_count, want.entry_count);
  endtask

  // Request driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      send_gap = 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_lookups = {expected_lookups, lookup_region(req_if.payload)};
        accepted_total++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_if.valid <= 1'b0;
        end else if (pixel_requests.size() > 0) begin
          req_if.payload <= pixel_requests.pop_front();
          req_if.valid   <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_lookups.size() == 0)
          report_mismatch("unexpected result, entry_slot", rsp_if.payload.entry_slot, 0);
        else
          check_result(rsp_if.payload, expected_lookups.pop_front());
        stall_left = pick_gap(stall_calm);
      end
      if (stall_left > 0) begin
        stall_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_record(logic [COLOR_W-1:0] c, logic [BOX_W-1:0] y, logic [BOX_W-1:0] x);
    req_t r;
    r.operation = OP_RECORD;
    r.color     = c;
    r.row       = y;
    r.column    = x;
    r.slot      = SLOT_W'($urandom);
    pixel_requests = {pixel_requests, r};
    issued_colors  = {issued_colors, c};
    queued_total++;
  endtask

  // Colour and coordinate fields carry noise on reads
  task automatic queue_read(logic [SLOT_W-1:0] s);
    req_t r;
    r.operation = OP_READ;
    r.color     = COLOR_W'($urandom);
    r.row       = BOX_W'($urandom);
    r.column    = BOX_W'($urandom);
    r.slot      = s;
    pixel_requests = {pixel_requests, r};
    queued_total++;
  endtask

  task automatic queue_random_record(logic [COLOR_W-1:0] c);
    queue_record(c, BOX_W'($urandom), BOX_W'($urandom));
  endtask

  function automatic logic [COLOR_W-1:0] known_color();
    return issued_colors[$urandom_range(0, issued_colors.size() - 1)];
  endfunction

  task automatic wait_drained();
    while (accepted_total != queued_total || expected_lookups.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0] palette [6];
    int unsigned        p;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    rst_n          = 1'b0;
    queued_total   = 0;
    accepted_total = 0;
    mismatches     = 0;
    send_calm      = 0;
    stall_calm     = 0;
    shadow_total   = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, corner colours and coordinates, widening, reads
    queue_read(8'h00);
    queue_read(8'hFF);
    queue_record('0, '0, '0);
    queue_record(COLOR_MAX, COORD_MAX, COORD_MAX);
    queue_record(COLOR_MAX, '0, '0);
    queue_record('0, COORD_MAX, COORD_MAX);
    queue_record('0, 12'h800, 12'h400);
    queue_record(24'hAAAAAA, 12'h555, 12'hAAA);
    queue_record(24'h555555, 12'hAAA, 12'h555);
    queue_record(24'hAAAAAA, 12'h000, 12'hFFF);
    queue_record(24'h555555, 12'hFFF, 12'h000);
    queue_read(8'h00);
    queue_read(8'h01);
    queue_read(8'h02);
    queue_read(8'h03);
    queue_read(8'h04);
    queue_read(8'hFF);
    queue_record(24'h000001, 12'h001, 12'h001);
    queue_read(8'h04);
    queue_read(8'h80);

    // Hold the sender until the table is quiet
    wait_drained();

    // Few colours, many pixels: mostly box widening
    palette[0] = '0;
    palette[1] = COLOR_MAX;
    for (int i = 2; i < 6; i++) palette[i] = COLOR_W'($urandom);
    for (int i = 0; i < 400; i++) begin
      p = $urandom_range(0, 99);
      if (p < 70) queue_random_record(palette[$urandom_range(0, 5)]);
      else if (p < 90) queue_read(SLOT_W'($urandom_range(0, 15)));
      else queue_read(SLOT_W'($urandom));
    end

    // Fill the table and run past capacity
    for (int i = 0; i < 600; i++) begin
      p = $urandom_range(0, 99);
      if (p < 50) queue_random_record(COLOR_W'($urandom));
      else if (p < 75) queue_random_record(known_color());
      else queue_read(SLOT_W'($urandom));
    end

    // Full table: hits anywhere, rejected colours, reads up to the top slot
    for (int i = 0; i < 700; i++) begin
      p = $urandom_range(0, 99);
      if (p < 35) queue_random_record(known_color());
      else if (p < 60) queue_random_record(COLOR_W'($urandom));
      else if (p < 70) queue_read(SLOT_W'($urandom_range(250, 255)));
      else queue_read(SLOT_W'($urandom));
    end

    wait_drained();
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("color_region_bounding_box_table_test: PASS");
    end else begin
      $display("color_region_bounding_box_table_test: FAIL");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("color_region_bounding_box_table_test: FAIL");
    $finish;
  end

endmodule
